[hdl/msp_rx_pkg.sv]
// Shared types and constants for the MSP v1 frame receiver.
// Used by msp_v1_frame_receiver; depends on nothing else.
package msp_rx_pkg;

  localparam logic [7:0] SYNC_DOLLAR = 8'h24;
  localparam logic [7:0] SYNC_M      = 8'h4D;
  localparam logic [7:0] DIR_DEFAULT = 8'h3C;

  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    HDR_DOLLAR,
    HDR_M,
    HDR_DIR,
    HDR_SIZE,
    HDR_CMD,
    HDR_BODY
  } hdr_state_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD   = 2'd0,
    EV_FRAME_OK  = 2'd1,
    EV_FRAME_BAD = 2'd2,
    EV_HDR_ERR   = 2'd3
  } ev_kind_t;

endpackage

[hdl/msp_v1_frame_receiver.sv]
// Top level of the MSP v1 frame receiver: byte input register, parser and result register.
// Depends on msp_rx_pkg for the header state type, event kinds and sync constants.

// The receiver takes one serial byte per item on the slave stream and parses frames of the
// form '$' 'M' direction size command payload checksum, where the checksum is the XOR of
// size, command and payload. Each payload byte gives one result item, the checksum byte
// gives a frame good or frame bad item, and any header mismatch (including idle noise
// while waiting for '$') gives a header error item and bumps a wrapping 16-bit counter.
// Matching header bytes give no result. A byte is accepted in every cycle while results
// are taken; each byte passes through an input register and then the parser into the
// result register, and its result is presented there once the result register is free.
// The expected direction byte is written through cfg_wen and cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce.
module msp_v1_frame_receiver
  import msp_rx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [7:0]            cfg_wdata,     // expected_direction
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // rx_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // command_code, payload_byte, payload_index, frame_size, error_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser,  // event_kind
  output logic                  m_axis_tlast   // frame_last
);

  logic [7:0]  expected_direction;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        proc_fire;

  hdr_state_t  state, state_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  declared_size, declared_size_next;
  logic [7:0]  current_command, current_command_next;
  logic [7:0]  running_checksum, running_checksum_next;
  logic [15:0] header_errors, header_errors_next;

  logic        emit;
  logic        hdr_fail;
  ev_kind_t    res_kind;
  logic [7:0]  res_cmd, res_byte, res_index, res_size;
  logic        res_last;

  logic        out_valid;
  ev_kind_t    out_kind;
  logic [7:0]  out_cmd, out_byte, out_index, out_size;
  logic        out_last;
  logic [15:0] out_errors;

  assign proc_fire     = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_direction <= DIR_DEFAULT;
    end else if (cfg_wen) begin
      expected_direction <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_comb begin
    state_next            = state;
    payload_count_next    = payload_count;
    declared_size_next    = declared_size;
    current_command_next  = current_command;
    running_checksum_next = running_checksum;
    header_errors_next    = header_errors;
    emit      = 1'b0;
    hdr_fail  = 1'b0;
    res_kind  = EV_PAYLOAD;
    res_cmd   = 8'd0;
    res_byte  = 8'd0;
    res_index = 8'd0;
    res_size  = 8'd0;
    res_last  = 1'b0;
    case (state)
      HDR_DOLLAR: begin
        if (in_byte != SYNC_DOLLAR) begin
          hdr_fail = 1'b1;
        end else begin
          state_next = HDR_M;
        end
      end
      HDR_M: begin
        if (in_byte != SYNC_M) begin
          hdr_fail = 1'b1;
        end else begin
          state_next = HDR_DIR;
        end
      end
      HDR_DIR: begin
        if (in_byte != expected_direction) begin
          hdr_fail = 1'b1;
        end else begin
          state_next = HDR_SIZE;
        end
      end
      HDR_SIZE: begin
        declared_size_next    = in_byte;
        running_checksum_next = in_byte;
        payload_count_next    = 8'd0;
        state_next            = HDR_CMD;
      end
      HDR_CMD: begin
        current_command_next  = in_byte;
        running_checksum_next = running_checksum ^ in_byte;
        state_next            = HDR_BODY;
      end
      HDR_BODY: begin
        emit     = 1'b1;
        res_cmd  = current_command;
        res_size = declared_size;
        if (payload_count >= declared_size) begin
          res_kind           = (in_byte == running_checksum) ? EV_FRAME_OK : EV_FRAME_BAD;
          res_last           = 1'b1;
          state_next         = HDR_DOLLAR;
          payload_count_next = 8'd0;
        end else begin
          res_byte              = in_byte;
          res_index             = payload_count;
          running_checksum_next = running_checksum ^ in_byte;
          payload_count_next    = payload_count + 8'd1;
        end
      end
      default: begin
        state_next = HDR_DOLLAR;
      end
    endcase
    if (hdr_fail) begin
      header_errors_next = header_errors + 16'd1;
      state_next         = HDR_DOLLAR;
      payload_count_next = 8'd0;
      emit               = 1'b1;
      res_kind           = EV_HDR_ERR;
      res_last           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= HDR_DOLLAR;
      payload_count    <= 8'd0;
      declared_size    <= 8'd0;
      current_command  <= 8'd0;
      running_checksum <= 8'd0;
      header_errors    <= 16'd0;
    end else if (proc_fire) begin
      state            <= state_next;
      payload_count    <= payload_count_next;
      declared_size    <= declared_size_next;
      current_command  <= current_command_next;
      running_checksum <= running_checksum_next;
      header_errors    <= header_errors_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      out_kind   <= res_kind;
      out_cmd    <= res_cmd;
      out_byte   <= res_byte;
      out_index  <= res_index;
      out_size   <= res_size;
      out_last   <= res_last;
      out_errors <= header_errors_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_errors, out_size, out_index, out_byte, out_cmd};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  // A header error always sends the parser back to the search for '$'.
  a_hdr_err_restart: assert property (@(posedge clk) disable iff (rst)
    proc_fire && hdr_fail |=> state == HDR_DOLLAR && payload_count == 8'd0)
    else $error("header error did not restart the search");

  // The error counter moves by exactly one on each header error and holds otherwise.
  a_err_count: assert property (@(posedge clk) disable iff (rst)
    proc_fire && hdr_fail |=> header_errors == $past(header_errors) + 16'd1)
    else $error("error counter did not advance on a header error");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    !(proc_fire && hdr_fail) |=> header_errors == $past(header_errors))
    else $error("error counter changed without a header error");

  // The payload count never passes the declared size while in the body of a frame.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == HDR_BODY |-> payload_count <= declared_size)
    else $error("payload count passed the declared size");

  // Every item but a payload byte closes a frame or reports an error.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_last == (out_kind != EV_PAYLOAD))
    else $error("frame end flag disagrees with the event kind");

endmodule

[tb/msp_v1_frame_receiver_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for msp_v1_frame_receiver: streams serial bytes and compares every
// result item with a behavioural parser kept in step. Depends on msp_rx_pkg and the receiver.
module msp_v1_frame_receiver_tb;
  import msp_rx_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS  = 40;

  typedef struct {
    ev_kind_t    kind;
    logic [7:0]  command;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [7:0]  size;
    logic        last;
    logic [15:0] errors;
  } rx_event_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [7:0]            cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  msp_v1_frame_receiver dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [7:0]  pending_bytes[$];
  rx_event_t   expected_events[$];

  hdr_state_t  hdr_pos = HDR_DOLLAR;
  logic [7:0]  body_count = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  frame_cmd = '0;
  logic [7:0]  xor_sum = '0;
  logic [7:0]  dir_byte = DIR_DEFAULT;
  logic [15:0] hdr_error_total = '0;

  bit          byte_accepted = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned items_queued = 0;
  int unsigned settings_used = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  initial begin
    forever #6 clk = ~clk;
  end

  function void predict_byte(input logic [7:0] b);
    rx_event_t ev;
    logic      hdr_miss;
    ev = '{EV_PAYLOAD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0};
    hdr_miss = 1'b0;
    case (hdr_pos)
      HDR_DOLLAR: if (b == SYNC_DOLLAR) hdr_pos = HDR_M; else hdr_miss = 1'b1;
      HDR_M:      if (b == SYNC_M) hdr_pos = HDR_DIR; else hdr_miss = 1'b1;
      HDR_DIR:    if (b == dir_byte) hdr_pos = HDR_SIZE; else hdr_miss = 1'b1;
      HDR_SIZE: begin
        frame_len = b;
        xor_sum = b;
        body_count = '0;
        hdr_pos = HDR_CMD;
      end
      HDR_CMD: begin
        frame_cmd = b;
        xor_sum = xor_sum ^ b;
        hdr_pos = HDR_BODY;
      end
      default: begin
        ev.command = frame_cmd;
        ev.size = frame_len;
        ev.errors = hdr_error_total;
        if (body_count >= frame_len) begin
          ev.kind = (b == xor_sum) ? EV_FRAME_OK : EV_FRAME_BAD;
          ev.last = 1'b1;
          hdr_pos = HDR_DOLLAR;
          body_count = '0;
        end else begin
          ev.kind = EV_PAYLOAD;
          ev.data = b;
          ev.index = body_count;
          xor_sum = xor_sum ^ b;
          body_count = body_count + 8'd1;
        end
        expected_events.push_back(ev);
      end
    endcase
    if (hdr_miss) begin
      hdr_error_total = hdr_error_total + 16'd1;
      hdr_pos = HDR_DOLLAR;
      body_count = '0;
      ev.kind = EV_HDR_ERR;
      ev.last = 1'b1;
      ev.errors = hdr_error_total;
      expected_events.push_back(ev);
    end
  endfunction

  function void check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    rx_event_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end else begin
      byte_accepted = !rst && s_axis_tvalid && s_axis_tready;
      if (byte_accepted) predict_byte(s_axis_tdata);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (expected_events.size() == 0) begin
          $error("result item with nothing expected: tuser 0x%0h tdata 0x%0h",
                 m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 16'(want.kind), 16'(m_axis_tuser));
          check_field("command_code", 16'(want.command), 16'(m_axis_tdata[7:0]));
          check_field("payload_byte", 16'(want.data), 16'(m_axis_tdata[15:8]));
          check_field("payload_index", 16'(want.index), 16'(m_axis_tdata[23:16]));
          check_field("frame_size", 16'(want.size), 16'(m_axis_tdata[31:24]));
          check_field("frame_last", 16'(want.last), 16'(m_axis_tlast));
          check_field("error_count", want.errors, m_axis_tdata[47:32]);
          kind_seen[want.kind]++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (byte_accepted) void'(pending_bytes.pop_front());
      if (!s_axis_tvalid || byte_accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_bytes[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  m_axis_tready <= 1'b1;
      STALL_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
      STALL_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:     m_axis_tready <= ~m_axis_tready;
    endcase
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    items_queued++;
  endtask

  task automatic push_frame(input logic [7:0] dir, input int unsigned len,
                            input logic [7:0] cmd, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'(len) ^ cmd;
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_M);
    push_byte(dir);
    push_byte(8'(len));
    push_byte(cmd);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      sum = sum ^ b;
      push_byte(b);
    end
    push_byte(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
  endtask

  task automatic random_traffic(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    start = items_queued;
    while (items_queued - start < n_items) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      if (pick < 70) begin
        push_frame(dir_byte, len, 8'($urandom), $urandom_range(0, 4) == 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end else if (pick < 92) begin
        push_byte(SYNC_DOLLAR);
        if ($urandom_range(0, 1) == 1) push_byte(SYNC_M);
        push_byte(8'($urandom));
      end else begin
        push_frame(dir_byte ^ 8'($urandom_range(1, 255)), len, 8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic write_direction(input logic [7:0] value);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    dir_byte = value;
    settings_used++;
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] settings[5];
    settings = '{8'h00, 8'hFF, 8'h3E, 8'($urandom), DIR_DEFAULT};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_direction(DIR_DEFAULT);

    // Idle noise, an empty frame, a bad checksum, a repeated sync byte and a wrong direction.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_M);
    push_byte(DIR_DEFAULT);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_M);
    push_byte(DIR_DEFAULT);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_M);
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_M);
    push_byte(8'h3E);
    wait_idle();

    foreach (settings[i]) begin
      write_direction(settings[i]);
      if (i == 1) push_frame(dir_byte, 255, 8'($urandom), 1'b0);
      random_traffic(PHASE_ITEMS);
      wait_idle();
    end

    $display("Sent %0d bytes under %0d direction settings: %0d good and %0d bad frames.",
             items_queued, settings_used, kind_seen[EV_FRAME_OK], kind_seen[EV_FRAME_BAD]);
    $display("Checked %0d payload items and %0d header errors.",
             kind_seen[EV_PAYLOAD], kind_seen[EV_HDR_ERR]);
    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
